// ===== hw/rtl/g2u_pkg.sv =====
// shared types and constants for the place record to unit vector pipeline
// no dependencies; imported by g2u_angle, g2u_poly and geo_record_to_unit_vector
package g2u_pkg;

  // key arithmetic
  localparam int unsigned KEY_STATE_MULT = 1000;
  localparam int unsigned KEY_MUNI_MULT  = 10000;
  localparam int          KEY_W          = 30;

  // pi in Q32, split in two halves for the radian conversion
  localparam logic [33:0] PI_Q32   = 34'h3243F6A89;
  localparam int          PI_SPLIT = 17;
  localparam logic [16:0] PI_HI    = PI_Q32[33:17];
  localparam logic [16:0] PI_LO    = PI_Q32[16:0];

  // scaled angle before the final divide by 45, and its two digits
  localparam int N_W     = 37;
  localparam int NL_W    = 18;
  localparam int NH_W    = N_W - NL_W;
  localparam int QH_W    = 13;
  localparam int RAD_DIV = 45;
  localparam int XR_W    = 31;

  localparam logic [31:0] Q31_ONE = 32'h8000_0000;

  localparam int SIN_STEPS = 6;
  localparam int COS_STEPS = 7;
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [COS_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

  // pipeline depths
  localparam int CDIV_LAT  = 2;
  localparam int STEP_LAT  = 2 + CDIV_LAT;
  localparam int ANGLE_LAT = 12;
  localparam int POLY_LAT  = STEP_LAT * COS_STEPS;
  localparam int TAIL_LAT  = 4;
  localparam int TOTAL_LAT = ANGLE_LAT + POLY_LAT + TAIL_LAT;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } g2u_quad_t;

  typedef struct packed {
    g2u_quad_t quad;
    logic      swap;
  } g2u_oct_t;

  typedef struct packed {
    logic [31:0] s_mag;
    logic        s_neg;
    logic [31:0] c_mag;
    logic        c_neg;
  } g2u_trig_t;

endpackage

// ===== hw/rtl/g2u_cdiv.sv =====
// pipelined divide by a constant: reciprocal multiply, then one correction step
// no dependencies; two register stages
module g2u_cdiv #(
  parameter int              W   = 31,
  parameter longint unsigned DIV = 3,
  parameter int              QW  = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  x,
  output logic [QW-1:0] q,
  output logic [W-1:0]  rem
);

  localparam longint unsigned M  = (64'd1 << W) / DIV;
  localparam int              MW = $clog2(M + 1);
  localparam int              PW = W + MW;

  logic [W-1:0]  x_r;
  logic [PW-1:0] prod_r;
  logic [PW-1:0] prod_nxt;
  logic [MW-1:0] qe;
  logic [PW-1:0] qd;
  logic [W-1:0]  rem0;
  logic          corr;
  logic [MW-1:0] q_r;
  logic [MW-1:0] q_nxt;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  rem_nxt;

  assign prod_nxt = PW'(x) * PW'(M);

  // estimate is the true quotient or one below it
  assign qe   = prod_r[PW-1:W];
  assign qd   = PW'(qe) * PW'(DIV);
  assign rem0 = x_r - qd[W-1:0];
  assign corr = rem0 >= W'(DIV);

  assign q_nxt   = corr ? qe + MW'(1) : qe;
  assign rem_nxt = corr ? rem0 - W'(DIV) : rem0;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x;
      prod_r <= prod_nxt;
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign q   = QW'(q_r);
  assign rem = rem_r;

endmodule

// ===== hw/rtl/g2u_angle.sv =====
// angle front end: reduce modulo 360 degrees, fold to one octant, convert to radians
// depends on g2u_pkg and g2u_cdiv; twelve register stages
module g2u_angle #(
  parameter int IW = 24,
  parameter int F  = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IW-1:0]   d,
  output logic [g2u_pkg::XR_W-1:0] xr,
  output logic [g2u_pkg::XR_W-1:0] s,
  output g2u_pkg::g2u_oct_t      oct
);

  import g2u_pkg::*;

  localparam longint unsigned FULL    = 64'd360 << F;
  localparam longint unsigned QUART   = 64'd90 << F;
  localparam longint unsigned HALFQ   = 64'd45 << F;
  localparam longint unsigned HALF_IN = 64'd1 << (IW - 1);
  localparam longint unsigned KOFF    = (HALF_IN + FULL - 1) / FULL;
  localparam longint unsigned OFF     = KOFF * FULL;
  localparam int              UW      = $clog2(OFF + HALF_IN);
  localparam int              RW      = $clog2(FULL);
  localparam int              PHW     = $clog2(HALFQ + 1);
  localparam int              MHW     = PHW + PI_SPLIT;
  localparam int              SIDE_D  = 7;

  localparam logic [RW-1:0] Q1_V = RW'(QUART);
  localparam logic [RW-1:0] Q2_V = RW'(2 * QUART);
  localparam logic [RW-1:0] Q3_V = RW'(3 * QUART);
  localparam logic [RW-1:0] H_V  = RW'(HALFQ);

  logic [63:0]       u_wide;
  logic [UW-1:0]     u_r;
  logic [UW-1:0]     red_rem;
  logic [RW-1:0]     r;
  g2u_quad_t         quad_nxt;
  logic [RW-1:0]     ru_nxt;
  g2u_quad_t         quad_r;
  logic [RW-1:0]     ru_r;
  logic [PHW-1:0]    phi_r;
  g2u_oct_t          oct5_r;
  logic [MHW-1:0]    mhi_r;
  logic [MHW-1:0]    mlo_r;
  logic [63:0]       nsum;
  logic [N_W-1:0]    n_r;
  logic [QH_W-1:0]   qh;
  logic [NH_W-1:0]   rh;
  logic [NL_W-1:0]   nl_d1_r;
  logic [NL_W-1:0]   nl_d2_r;
  logic [NL_W+5:0]   y;
  logic [NL_W-1:0]   ql;
  logic [QH_W-1:0]   qh_d1_r;
  logic [QH_W-1:0]   qh_d2_r;
  logic [XR_W-1:0]   xr_nxt;
  logic [2*XR_W-1:0] sq;
  logic [XR_W-1:0]   xr_r;
  logic [XR_W-1:0]   s_r;
  g2u_oct_t          oct_pipe_r [1:SIDE_D];

  // offset by a multiple of a full turn so the dividend is never negative
  assign u_wide = 64'(longint'(d)) + OFF;

  g2u_cdiv #(.W(UW), .DIV(FULL), .QW(1)) u_mod (
    .clk (clk),
    .en  (en),
    .x   (u_r),
    .q   (),
    .rem (red_rem)
  );

  assign r = red_rem[RW-1:0];

  always_comb begin
    if (r >= Q3_V) begin
      quad_nxt = QUAD_3;
      ru_nxt   = r - Q3_V;
    end else if (r >= Q2_V) begin
      quad_nxt = QUAD_2;
      ru_nxt   = r - Q2_V;
    end else if (r >= Q1_V) begin
      quad_nxt = QUAD_1;
      ru_nxt   = r - Q1_V;
    end else begin
      quad_nxt = QUAD_0;
      ru_nxt   = r;
    end
  end

  // degrees * pi / 180, rounded, taken as one divide by 45 after a shift
  assign nsum = (64'(mhi_r) << PI_SPLIT) + 64'(mlo_r) + (64'd180 << F);

  g2u_cdiv #(.W(NH_W), .DIV(RAD_DIV), .QW(QH_W)) u_div_hi (
    .clk (clk),
    .en  (en),
    .x   (n_r[N_W-1:NL_W]),
    .q   (qh),
    .rem (rh)
  );

  assign y = {rh[5:0], nl_d2_r};

  g2u_cdiv #(.W(NL_W + 6), .DIV(RAD_DIV), .QW(NL_W)) u_div_lo (
    .clk (clk),
    .en  (en),
    .x   (y),
    .q   (ql),
    .rem ()
  );

  assign xr_nxt = {qh_d2_r, ql};
  assign sq     = (2 * XR_W)'(xr_nxt) * (2 * XR_W)'(xr_nxt);

  always_ff @(posedge clk) begin
    if (en) begin
      u_r        <= u_wide[UW-1:0];
      quad_r     <= quad_nxt;
      ru_r       <= ru_nxt;
      phi_r      <= (ru_r <= H_V) ? PHW'(ru_r) : PHW'(Q1_V - ru_r);
      oct5_r     <= '{quad: quad_r, swap: (ru_r > H_V)};
      mhi_r      <= MHW'(phi_r) * MHW'(PI_HI);
      mlo_r      <= MHW'(phi_r) * MHW'(PI_LO);
      n_r        <= N_W'(nsum >> (F + 3));
      nl_d1_r    <= n_r[NL_W-1:0];
      nl_d2_r    <= nl_d1_r;
      qh_d1_r    <= qh;
      qh_d2_r    <= qh_d1_r;
      xr_r       <= xr_nxt;
      s_r        <= sq[2*XR_W-1:XR_W];
      oct_pipe_r[1] <= oct5_r;
      for (int j = 2; j <= SIDE_D; j++) begin
        oct_pipe_r[j] <= oct_pipe_r[j-1];
      end
    end
  end

  assign xr  = xr_r;
  assign s   = s_r;
  assign oct = oct_pipe_r[SIDE_D];

endmodule

// ===== hw/rtl/g2u_poly.sv =====
// sine and cosine series in Q1.31, one Horner step per four register stages
// depends on g2u_pkg and g2u_cdiv
module g2u_poly (
  input  logic                     clk,
  input  logic                     en,
  input  logic [g2u_pkg::XR_W-1:0] xr,
  input  logic [g2u_pkg::XR_W-1:0] s,
  input  g2u_pkg::g2u_oct_t        oct_in,
  output logic [31:0]              sin_mag,
  output logic [31:0]              cos_mag,
  output g2u_pkg::g2u_oct_t        oct_out
);

  import g2u_pkg::*;

  localparam int S_DEPTH  = STEP_LAT * (COS_STEPS - 1);
  localparam int XR_DEPTH = STEP_LAT * SIN_STEPS;
  localparam int SIN_PAD  = POLY_LAT - XR_DEPTH - 1;

  logic [XR_W-1:0]   s_pipe_r   [1:S_DEPTH];
  logic [XR_W-1:0]   s_tap      [0:S_DEPTH];
  logic [XR_W-1:0]   xr_pipe_r  [1:XR_DEPTH];
  g2u_oct_t          oct_pipe_r [1:POLY_LAT];
  logic [31:0]       t_s        [0:SIN_STEPS];
  logic [31:0]       t_c        [0:COS_STEPS];
  logic [2*XR_W+1:0] sin_prod;
  logic [31:0]       sin_pipe_r [0:SIN_PAD];

  assign s_tap[0] = s;
  assign t_s[0]   = Q31_ONE;
  assign t_c[0]   = Q31_ONE;

  for (genvar j = 1; j <= S_DEPTH; j++) begin : g_tap
    assign s_tap[j] = s_pipe_r[j];
  end

  for (genvar k = 0; k < SIN_STEPS; k++) begin : g_sin
    logic [XR_W-1:0] p_r;
    logic [XR_W-1:0] q;
    logic [31:0]     t_r;
    logic [63:0]     prod;

    assign prod = 64'(s_tap[STEP_LAT*k]) * 64'(t_s[k]);

    g2u_cdiv #(.W(XR_W), .DIV(64'(SIN_DIV[k])), .QW(XR_W)) u_div (
      .clk (clk),
      .en  (en),
      .x   (p_r),
      .q   (q),
      .rem ()
    );

    always_ff @(posedge clk) begin
      if (en) begin
        p_r <= prod[61:31];
        t_r <= Q31_ONE - 32'(q);
      end
    end

    assign t_s[k+1] = t_r;
  end

  for (genvar k = 0; k < COS_STEPS; k++) begin : g_cos
    logic [XR_W-1:0] p_r;
    logic [XR_W-1:0] q;
    logic [31:0]     t_r;
    logic [63:0]     prod;

    assign prod = 64'(s_tap[STEP_LAT*k]) * 64'(t_c[k]);

    g2u_cdiv #(.W(XR_W), .DIV(64'(COS_DIV[k])), .QW(XR_W)) u_div (
      .clk (clk),
      .en  (en),
      .x   (p_r),
      .q   (q),
      .rem ()
    );

    always_ff @(posedge clk) begin
      if (en) begin
        p_r <= prod[61:31];
        t_r <= Q31_ONE - 32'(q);
      end
    end

    assign t_c[k+1] = t_r;
  end

  // sine needs the angle itself once more, then waits for the longer cosine chain
  assign sin_prod = (2 * XR_W + 2)'(xr_pipe_r[XR_DEPTH]) * (2 * XR_W + 2)'(t_s[SIN_STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      s_pipe_r[1]   <= s;
      xr_pipe_r[1]  <= xr;
      oct_pipe_r[1] <= oct_in;
      for (int j = 2; j <= S_DEPTH; j++) begin
        s_pipe_r[j] <= s_pipe_r[j-1];
      end
      for (int j = 2; j <= XR_DEPTH; j++) begin
        xr_pipe_r[j] <= xr_pipe_r[j-1];
      end
      for (int j = 2; j <= POLY_LAT; j++) begin
        oct_pipe_r[j] <= oct_pipe_r[j-1];
      end
      sin_pipe_r[0] <= 32'(sin_prod >> 31);
      for (int j = 1; j <= SIN_PAD; j++) begin
        sin_pipe_r[j] <= sin_pipe_r[j-1];
      end
    end
  end

  assign sin_mag = sin_pipe_r[SIN_PAD];
  assign cos_mag = t_c[COS_STEPS];
  assign oct_out = oct_pipe_r[POLY_LAT];

endmodule

// ===== hw/rtl/geo_record_to_unit_vector.sv =====
// place record to key and unit sphere vector, fully pipelined
// pipeline: angle front end, then sine and cosine series, then the combine stages
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// reset: synchronous, active low, clears the valid bits only
// depends on g2u_pkg, g2u_angle, g2u_poly
module geo_record_to_unit_vector #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [6:0]         in_state_code,
  input  logic [9:0]         in_municipality_code,
  input  logic [13:0]        in_locality_code,
  input  logic signed [23:0] in_latitude_deg,
  input  logic signed [24:0] in_longitude_deg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [29:0]        out_place_key,
  output logic signed [31:0] out_unit_x,
  output logic signed [31:0] out_unit_y,
  output logic signed [31:0] out_unit_z
);

  import g2u_pkg::*;

  localparam int PSH = 62 - OUT_FRAC_BITS;
  localparam int ZSH = 31 - OUT_FRAC_BITS;

  logic                en;
  logic [TOTAL_LAT:1]  vld_r;
  logic [16:0]         key_a_r;
  logic [13:0]         loc_r;
  logic [KEY_W-1:0]    key_pipe_r [2:TOTAL_LAT];
  logic [XR_W-1:0]     lat_xr;
  logic [XR_W-1:0]     lat_s;
  g2u_oct_t            lat_oct;
  logic [XR_W-1:0]     lng_xr;
  logic [XR_W-1:0]     lng_s;
  g2u_oct_t            lng_oct;
  logic [31:0]         lat_sin;
  logic [31:0]         lat_cos;
  g2u_oct_t            lat_oct_p;
  logic [31:0]         lng_sin;
  logic [31:0]         lng_cos;
  g2u_oct_t            lng_oct_p;
  g2u_trig_t           lat_r;
  g2u_trig_t           lng_r;
  logic [63:0]         x_prod_r;
  logic [63:0]         y_prod_r;
  logic                x_neg_r;
  logic                y_neg_r;
  logic [31:0]         z_mag_r;
  logic                z_neg_r;
  logic [30:0]         x_m_r;
  logic [30:0]         y_m_r;
  logic [30:0]         z_m_r;
  logic                x_neg2_r;
  logic                y_neg2_r;
  logic                z_neg2_r;
  logic [31:0]         out_x_r;
  logic [31:0]         out_y_r;
  logic [31:0]         out_z_r;

  function automatic g2u_trig_t place_quadrant(input logic [31:0] sn, input logic [31:0] cs,
                                               input g2u_oct_t oct);
    g2u_trig_t   t;
    logic [31:0] s0;
    logic [31:0] c0;
    s0 = oct.swap ? cs : sn;
    c0 = oct.swap ? sn : cs;
    case (oct.quad)
      QUAD_0: t = '{s_mag: s0, s_neg: 1'b0, c_mag: c0, c_neg: 1'b0};
      QUAD_1: t = '{s_mag: c0, s_neg: 1'b0, c_mag: s0, c_neg: 1'b1};
      QUAD_2: t = '{s_mag: s0, s_neg: 1'b1, c_mag: c0, c_neg: 1'b1};
      QUAD_3: t = '{s_mag: c0, s_neg: 1'b1, c_mag: s0, c_neg: 1'b0};
      default: t = '{s_mag: s0, s_neg: 1'b0, c_mag: c0, c_neg: 1'b0};
    endcase
    return t;
  endfunction

  assign out_valid = vld_r[TOTAL_LAT];
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL_LAT-1:1], in_valid};
    end
  end

  g2u_angle #(.IW(24), .F(ANGLE_FRAC_BITS)) u_lat_angle (
    .clk (clk),
    .en  (en),
    .d   (in_latitude_deg),
    .xr  (lat_xr),
    .s   (lat_s),
    .oct (lat_oct)
  );

  g2u_angle #(.IW(25), .F(ANGLE_FRAC_BITS)) u_lng_angle (
    .clk (clk),
    .en  (en),
    .d   (in_longitude_deg),
    .xr  (lng_xr),
    .s   (lng_s),
    .oct (lng_oct)
  );

  g2u_poly u_lat_poly (
    .clk     (clk),
    .en      (en),
    .xr      (lat_xr),
    .s       (lat_s),
    .oct_in  (lat_oct),
    .sin_mag (lat_sin),
    .cos_mag (lat_cos),
    .oct_out (lat_oct_p)
  );

  g2u_poly u_lng_poly (
    .clk     (clk),
    .en      (en),
    .xr      (lng_xr),
    .s       (lng_s),
    .oct_in  (lng_oct),
    .sin_mag (lng_sin),
    .cos_mag (lng_cos),
    .oct_out (lng_oct_p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      // place key, wraps to its field width
      key_a_r       <= 17'(17'(in_state_code) * 17'(KEY_STATE_MULT)
                           + 17'(in_municipality_code));
      loc_r         <= in_locality_code;
      key_pipe_r[2] <= KEY_W'(34'(key_a_r) * 34'(KEY_MUNI_MULT) + 34'(loc_r));
      for (int j = 3; j <= TOTAL_LAT; j++) begin
        key_pipe_r[j] <= key_pipe_r[j-1];
      end

      lat_r <= place_quadrant(lat_sin, lat_cos, lat_oct_p);
      lng_r <= place_quadrant(lng_sin, lng_cos, lng_oct_p);

      x_prod_r <= 64'(lng_r.s_mag) * 64'(lat_r.c_mag);
      y_prod_r <= 64'(lng_r.c_mag) * 64'(lat_r.c_mag);
      x_neg_r  <= lng_r.s_neg ^ lat_r.c_neg;
      y_neg_r  <= lng_r.c_neg ^ lat_r.c_neg;
      z_mag_r  <= lat_r.s_mag;
      z_neg_r  <= lat_r.s_neg;

      // round half up in magnitude
      x_m_r    <= 31'((x_prod_r + (64'd1 << (PSH - 1))) >> PSH);
      y_m_r    <= 31'((y_prod_r + (64'd1 << (PSH - 1))) >> PSH);
      z_m_r    <= 31'((33'(z_mag_r) + (33'd1 << (ZSH - 1))) >> ZSH);
      x_neg2_r <= x_neg_r;
      y_neg2_r <= y_neg_r;
      z_neg2_r <= z_neg_r;

      out_x_r <= x_neg2_r ? 32'd0 - 32'(x_m_r) : 32'(x_m_r);
      out_y_r <= y_neg2_r ? 32'd0 - 32'(y_m_r) : 32'(y_m_r);
      out_z_r <= z_neg2_r ? 32'd0 - 32'(z_m_r) : 32'(z_m_r);
    end
  end

  assign out_place_key = key_pipe_r[TOTAL_LAT];
  assign out_unit_x    = out_x_r;
  assign out_unit_y    = out_y_r;
  assign out_unit_z    = out_z_r;

endmodule

// ===== hw/rtl/g2u_checker.sv =====
// port level checks for geo_record_to_unit_vector, attached by bind
// no package dependency
module g2u_port_checks #(
  parameter int OUT_FRAC_BITS = 30
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [29:0]        out_place_key,
  input logic signed [31:0] out_unit_x,
  input logic signed [31:0] out_unit_y,
  input logic signed [31:0] out_unit_z
);

  localparam logic signed [31:0] LIM  = 32'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [31:0] NLIM = -LIM;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_place_key) && $stable(out_unit_x)
                               && $stable(out_unit_y) && $stable(out_unit_z))
    else $error("stalled item changed");

  // input only backs up when a finished item is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unit_x <= LIM && out_unit_x >= NLIM && out_unit_y <= LIM
                  && out_unit_y >= NLIM && out_unit_z <= LIM && out_unit_z >= NLIM)
    else $error("vector component out of range");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind geo_record_to_unit_vector g2u_port_checks #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_g2u_checker (.*);

// ===== dv/g2u_checker.sv =====
// checker for geo_record_to_unit_vector: watches both channels, predicts each result
// from the accepted item and compares it field by field; depends on nothing else
module g2u_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [6:0]         in_state_code,
  input  logic [9:0]         in_municipality_code,
  input  logic [13:0]        in_locality_code,
  input  logic signed [23:0] in_latitude_deg,
  input  logic signed [24:0] in_longitude_deg,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [29:0]        out_place_key,
  input  logic signed [31:0] out_unit_x,
  input  logic signed [31:0] out_unit_y,
  input  logic signed [31:0] out_unit_z,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_IN  = 16;
  localparam int FRAC_OUT = 30;
  localparam logic [63:0] ONE_Q31 = 64'h8000_0000;
  localparam logic [63:0] PI_Q32 = 64'h3_243F_6A89;

  typedef struct packed {
    logic [29:0] key;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vec_t;

  vec_t want_q[$];

  // phi in [0,45] degrees -> sine and cosine magnitudes in Q1.31
  task automatic octant_sin_cos(input logic [63:0] phi, output logic [63:0] sn,
                                output logic [63:0] cs);
    logic [63:0] xr, s, t;
    int sdiv[6];
    int cdiv[7];
    sdiv = '{156, 110, 72, 42, 20, 6};
    cdiv = '{182, 132, 90, 56, 30, 12, 2};
    xr = ((phi * PI_Q32) / 180 + (64'd1 << FRAC_IN)) >> (FRAC_IN + 1);
    s = (xr * xr) >> 31;
    t = ONE_Q31;
    for (int k = 0; k < 6; k++) t = ONE_Q31 - ((s * t) >> 31) / sdiv[k];
    sn = (xr * t) >> 31;
    t = ONE_Q31;
    for (int k = 0; k < 7; k++) t = ONE_Q31 - ((s * t) >> 31) / cdiv[k];
    cs = t;
  endtask

  task automatic angle_sin_cos(input longint deg, output longint sn, output longint cs);
    longint full, quart, r, u;
    logic [63:0] a, b, s0, c0;
    int q;
    full = 360 << FRAC_IN;
    quart = 90 << FRAC_IN;
    r = deg % full;
    if (r < 0) r += full;
    q = int'(r / quart);
    u = r - q * quart;
    if (u <= (45 << FRAC_IN)) begin
      octant_sin_cos(u, a, b);
      s0 = a; c0 = b;
    end else begin
      octant_sin_cos(quart - u, a, b);
      s0 = b; c0 = a;
    end
    case (q & 3)
      0: begin sn = s0;  cs = c0;  end
      1: begin sn = c0;  cs = -s0; end
      2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endtask

  function automatic logic [31:0] round_product(longint a, longint b);
    logic [63:0] ma, mb, m;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    m = (ma * mb + (64'd1 << (61 - FRAC_OUT))) >> (62 - FRAC_OUT);
    return ((a < 0) != (b < 0)) ? -m[31:0] : m[31:0];
  endfunction

  function automatic logic [31:0] round_sine(longint v);
    logic [63:0] m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (30 - FRAC_OUT))) >> (31 - FRAC_OUT);
    return v < 0 ? -m[31:0] : m[31:0];
  endfunction

  always @(posedge clk) begin
    vec_t e, got;
    longint slat, clat, slng, clng;
    logic [63:0] wide;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        angle_sin_cos(longint'(in_latitude_deg), slat, clat);
        angle_sin_cos(longint'(in_longitude_deg), slng, clng);
        wide = (64'(in_state_code) * 1000 + in_municipality_code) * 10000 + in_locality_code;
        e.key = wide[29:0];
        e.x = round_product(slng, clat);
        e.y = round_product(clng, clat);
        e.z = round_sine(slat);
        want_q.push_back(e);
      end
      if (out_valid && !out_stall) begin
        got = '{out_place_key, out_unit_x, out_unit_y, out_unit_z};
        result_count <= result_count + 1;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result key %0d", $time, got.key);
          fail_count <= fail_count + 1;
        end else begin
          e = want_q.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch key exp %0d got %0d", $time, e.key, got.key);
            $display("%0t:   x exp %0d got %0d  y exp %0d got %0d  z exp %0d got %0d",
                     $time, $signed(e.x), $signed(got.x), $signed(e.y), $signed(got.y),
                     $signed(e.z), $signed(got.z));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= want_q.size();
  end
endmodule

// ===== dv/tb_geo_record_to_unit_vector.sv =====
// testbench top for geo_record_to_unit_vector: clock, reset, stimulus and verdict
// depends on the block and on g2u_checker
module tb_geo_record_to_unit_vector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1100;
  localparam int LATENCY = 44;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [6:0]         in_state_code = '0;
  logic [9:0]         in_municipality_code = '0;
  logic [13:0]        in_locality_code = '0;
  logic signed [23:0] in_latitude_deg = '0;
  logic signed [24:0] in_longitude_deg = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [29:0]        out_place_key;
  logic signed [31:0] out_unit_x, out_unit_y, out_unit_z;
  int                 fail_count, pending, result_count;
  int                 cycles = 0;
  int                 sent = 0;

  always #1 clk = ~clk;

  geo_record_to_unit_vector dut (.*);

  g2u_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_geo_record_to_unit_vector NOT OK");
      $finish;
    end
  end

  // receiver stalls in runs: quiet stretches, then heavy or light stall phases
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic send_item(input logic [6:0] st, input logic [9:0] mu, input logic [13:0] lo,
                           input logic [23:0] la, input logic [24:0] lg);
    in_valid <= 1'b1;
    in_state_code <= st;
    in_municipality_code <= mu;
    in_locality_code <= lo;
    in_latitude_deg <= la;
    in_longitude_deg <= lg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // angle mostly in the normal range, sometimes on a multiple of 45 degrees, sometimes anywhere the field allows
  function automatic logic [24:0] pick_angle(int range_deg, int width);
    logic [24:0] v;
    case ($urandom_range(0, 9))
      0: v = 25'($urandom);
      1: v = 25'($signed(($urandom_range(0, 8) * 45 - range_deg) << 16));
      default: v = 25'($signed($urandom_range(0, 2 * (range_deg << 16))) - (range_deg << 16));
    endcase
    return width == 24 ? 25'($signed(v[23:0])) : v;
  endfunction

  initial begin
    int burst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed: code extremes, out-of-range codes, octant edges, beyond-range angles
    send_item(0, 0, 0, 0, 0);
    send_item(99, 999, 9999, 24'sd5898240, 25'sd11796480);
    send_item(7'h7f, 10'h3ff, 14'h3fff, -24'sd5898240, -25'sd11796480);
    send_item(1, 2, 3, 24'sd2949120, 25'sd2949120);
    send_item(4, 5, 6, -24'sd2949120, -25'sd5898240);
    send_item(50, 500, 5000, 24'sd2949121, 25'sd2949119);
    send_item(10, 10, 10, 24'h7fffff, 25'h0ffffff);
    send_item(11, 11, 11, 24'h800000, 25'h1000000);
    send_item(12, 12, 12, -24'sd7929856, -25'sd15859712);
    send_item(13, 13, 13, 24'sd1, -25'sd1);
    send_item(14, 14, 14, -24'sd1, 25'sd1);
    send_item(15, 15, 15, 24'sd5898239, 25'sd8847360);
    send_item(16, 16, 16, -24'sd5898241, -25'sd8847360);
    send_item(17, 17, 17, 24'sd1474560, -25'sd9961472);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      logic [6:0] st;
      logic [9:0] mu;
      logic [13:0] lo;
      logic [24:0] la_w;
      logic [24:0] lg_w;
      if (burst <= 0) begin
        burst = $urandom_range(1, 40);
        idle_gap();
      end
      burst--;
      st = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
      mu = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 999));
      lo = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 9999));
      la_w = pick_angle(90, 24);
      lg_w = pick_angle(180, 25);
      send_item(st, mu, lo, la_w[23:0], lg_w);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d records, %0d results checked, over codes and angles", sent,
             result_count);
    $display("angles covered all octants and wrapped beyond the nominal range");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_geo_record_to_unit_vector OK");
    end else begin
      $display("tb_geo_record_to_unit_vector NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/g2u_pkg.sv
hw/rtl/g2u_cdiv.sv
hw/rtl/g2u_angle.sv
hw/rtl/g2u_poly.sv
hw/rtl/geo_record_to_unit_vector.sv
hw/rtl/g2u_checker.sv
dv/g2u_checker.sv
dv/tb_geo_record_to_unit_vector.sv
